// ----- rtl/ctce_pkg.sv -----
`default_nettype none

package ctce_pkg;

    // parse phases
    localparam logic [3:0] PH_MAIN     = 4'd0;
    localparam logic [3:0] PH_SUB      = 4'd1;
    localparam logic [3:0] PH_PRE_SEMI = 4'd2;
    localparam logic [3:0] PH_PRE_KEY  = 4'd3;
    localparam logic [3:0] PH_KEY      = 4'd4;
    localparam logic [3:0] PH_PRE_EQ   = 4'd5;
    localparam logic [3:0] PH_POST_EQ  = 4'd6;
    localparam logic [3:0] PH_TOKEN    = 4'd7;
    localparam logic [3:0] PH_QUOTED   = 4'd8;
    localparam logic [3:0] PH_DONE     = 4'd9;

    // result status codes
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    localparam int unsigned START_W = 12;
    localparam int unsigned LEN_W   = 13;
    localparam logic [2:0]  KEY_LEN = 3'd7;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;

    typedef struct packed {
        logic [LEN_W-1:0]   value_length;
        logic [START_W-1:0] value_start;
        logic [1:0]         status;
    } t_result;

    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic f_is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic f_is_ctl(input logic [7:0] c);
        return (c < 8'd32) || c[7];
    endfunction

    function automatic logic f_is_special(input logic [7:0] c);
        logic r;
        case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B,
            8'h3A, 8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // letters of "charset"
    function automatic logic [7:0] f_key_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = 8'h63;
            3'd1: r = 8'h68;
            3'd2: r = 8'h61;
            3'd3: r = 8'h72;
            3'd4: r = 8'h73;
            3'd5: r = 8'h65;
            3'd6: r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ctce_parser.sv -----
`default_nettype none

module ctce_parser #(
    parameter int unsigned MAX_LENGTH = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_final,
    output ctce_pkg::t_result    o_result
);
    import ctce_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_LENGTH + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

    logic [3:0]       r_phase,   n_phase;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [2:0]       r_kidx,    n_kidx;
    logic             r_kmis,    n_kmis;
    logic [POS_W-1:0] r_vb,      n_vb;
    logic [POS_W-1:0] r_last,    n_last;
    logic             r_esc,     n_esc;
    logic [1:0]       r_verdict, n_verdict;

    logic [POS_W-1:0] pos_inc;
    logic             key_ok;
    logic             do_tok;
    logic             pre_key;
    logic [7:0]       low;
    logic [POS_W-1:0] diff;
    t_result          res;

    assign pos_inc = r_pos + 1'b1;
    assign key_ok  = !r_kmis && (r_kidx == KEY_LEN);
    assign low     = f_to_lower(i_byte);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_kidx    = r_kidx;
        n_kmis    = r_kmis;
        n_vb      = r_vb;
        n_last    = r_last;
        n_esc     = r_esc;
        n_verdict = r_verdict;
        do_tok    = 1'b0;
        pre_key   = 1'b0;
        res       = '0;
        diff      = '0;

        if (r_pos >= POS_MAX) begin
            n_phase   = PH_DONE;
            n_verdict = ST_LONG;
        end else begin
            n_pos = pos_inc;
            case (r_phase)
                PH_MAIN: begin
                    if (i_byte == CH_SLASH) begin
                        n_phase = PH_SUB;
                    end else if (f_is_ws(i_byte) || i_byte == CH_SEMI) begin
                        n_phase   = PH_DONE;
                        n_verdict = ST_BAD;
                    end
                end
                PH_SUB: begin
                    if (i_byte == CH_SEMI) begin
                        pre_key = 1'b1;
                    end else if (i_byte == CH_SLASH) begin
                        n_phase   = PH_DONE;
                        n_verdict = ST_BAD;
                    end
                end
                PH_PRE_SEMI: begin
                    if (i_byte == CH_SEMI) begin
                        pre_key = 1'b1;
                    end else if (!f_is_ws(i_byte)) begin
                        n_phase   = PH_DONE;
                        n_verdict = ST_BAD;
                    end
                end
                PH_PRE_KEY, PH_KEY: begin
                    if (f_is_ws(i_byte)) begin
                        if (r_phase == PH_KEY) begin
                            n_phase = PH_PRE_EQ;
                        end
                    end else if (i_byte == CH_EQ) begin
                        n_phase = PH_POST_EQ;
                    end else if (f_is_special(i_byte) || f_is_ctl(i_byte)) begin
                        n_phase   = PH_DONE;
                        n_verdict = ST_BAD;
                    end else begin
                        if (r_kidx < KEY_LEN && low == f_key_char(r_kidx)) begin
                            n_kidx = r_kidx + 1'b1;
                        end else begin
                            n_kmis = 1'b1;
                        end
                        n_phase = PH_KEY;
                    end
                end
                PH_PRE_EQ: begin
                    if (i_byte == CH_EQ) begin
                        n_phase = PH_POST_EQ;
                    end else if (!f_is_ws(i_byte)) begin
                        n_phase   = PH_DONE;
                        n_verdict = ST_BAD;
                    end
                end
                PH_POST_EQ: begin
                    if (f_is_ws(i_byte)) begin
                        n_phase = r_phase;
                    end else if (i_byte == CH_QUOTE) begin
                        n_phase = PH_QUOTED;
                        n_vb    = pos_inc;
                        n_last  = pos_inc;
                        n_esc   = 1'b0;
                    end else begin
                        n_vb   = r_pos;
                        do_tok = 1'b1;
                    end
                end
                PH_TOKEN: begin
                    do_tok = 1'b1;
                end
                PH_QUOTED: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (i_byte == CH_QUOTE) begin
                            n_last = pos_inc;
                        end else begin
                            n_phase   = PH_DONE;
                            n_verdict = ST_BAD;
                        end
                    end else if (i_byte == CH_NUL) begin
                        n_phase   = PH_DONE;
                        n_verdict = ST_BAD;
                    end else if (i_byte == CH_BSLASH) begin
                        n_esc  = 1'b1;
                        n_last = pos_inc;
                    end else if (i_byte == CH_QUOTE) begin
                        if (key_ok) begin
                            n_phase   = PH_DONE;
                            n_verdict = (r_last > r_vb) ? ST_FOUND : ST_NONE;
                        end else begin
                            n_phase = PH_PRE_SEMI;
                        end
                    end else if (f_is_blank(i_byte)) begin
                        // drop leading blanks inside the quotes
                        if (r_last == r_vb) begin
                            n_vb   = pos_inc;
                            n_last = pos_inc;
                        end
                    end else begin
                        n_last = pos_inc;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (do_tok) begin
                if (f_is_ws(i_byte) || i_byte == CH_SEMI) begin
                    if (key_ok) begin
                        n_last    = r_pos;
                        n_phase   = PH_DONE;
                        n_verdict = (r_pos > n_vb) ? ST_FOUND : ST_NONE;
                    end else if (i_byte == CH_SEMI) begin
                        pre_key = 1'b1;
                    end else begin
                        n_phase = PH_PRE_SEMI;
                    end
                end else if (f_is_special(i_byte) || f_is_ctl(i_byte)) begin
                    n_phase   = PH_DONE;
                    n_verdict = ST_BAD;
                end else begin
                    n_phase = PH_TOKEN;
                end
            end

            if (pre_key) begin
                n_phase = PH_PRE_KEY;
                n_kidx  = '0;
                n_kmis  = 1'b0;
                n_esc   = 1'b0;
            end
        end

        // close out the string on its last byte
        if (i_final) begin
            case (n_phase)
                PH_SUB, PH_PRE_SEMI: begin
                    n_verdict = ST_NONE;
                end
                PH_TOKEN: begin
                    if (key_ok) begin
                        n_last    = n_pos;
                        n_verdict = (n_pos > n_vb) ? ST_FOUND : ST_NONE;
                    end else begin
                        n_verdict = ST_NONE;
                    end
                end
                PH_DONE: begin
                    n_verdict = n_verdict;
                end
                default: begin
                    n_verdict = ST_BAD;
                end
            endcase
            res.status = n_verdict;
            if (n_verdict == ST_FOUND && n_last >= n_vb) begin
                diff             = n_last - n_vb;
                res.value_start  = START_W'(n_vb);
                res.value_length = LEN_W'(diff);
            end
            n_phase   = PH_MAIN;
            n_pos     = '0;
            n_kidx    = '0;
            n_kmis    = 1'b0;
            n_vb      = '0;
            n_last    = '0;
            n_esc     = 1'b0;
            n_verdict = ST_NONE;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAIN;
            r_pos     <= '0;
            r_kidx    <= '0;
            r_kmis    <= 1'b0;
            r_vb      <= '0;
            r_last    <= '0;
            r_esc     <= 1'b0;
            r_verdict <= ST_NONE;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_kidx    <= n_kidx;
            r_kmis    <= n_kmis;
            r_vb      <= n_vb;
            r_last    <= n_last;
            r_esc     <= n_esc;
            r_verdict <= n_verdict;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/content_type_charset_extractor.sv -----
// Charset finder for a Content-Type header string.
// Input channel (i_s_*): one string byte per item, tlast marks the final byte.
// Output channel (o_m_*): one item per string, sent after its final byte,
// carrying status, offset and length of the charset value.
// A final byte accepted into the input register loads the result register once
// that register is free; the result is then offered on the output channel.
// Throughput: one byte per cycle while no final byte waits for the result slot;
// the next parse state and result are combinational from the input register.
// Stall: while a result waits in the output register, non-final bytes keep
// flowing; a final byte holds in the input register until the result is taken.
// Reset: synchronous, active low; clears handshake state and returns the
// parser to the start of a new string. No clearing pass is needed.
// Strings longer than MAX_LENGTH bytes report status 3.
`default_nettype none

module content_type_charset_extractor #(
    parameter int unsigned MAX_LENGTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // text_byte[7:0]
    input  wire logic        i_s_tlast,    // final_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata     // status[1:0], value_start[13:2],
                                           // value_length[26:14], zero[31:27]
);
    import ctce_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_vld;
    t_result    r_out;
    t_result    core_res;
    logic       adv;

    // advance the held byte unless it is final and the result slot is busy
    assign adv        = r_in_vld && (!r_in_last || !r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    ctce_parser #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_byte   (r_in_byte),
        .i_final  (r_in_last),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out.value_length, r_out.value_start, r_out.status};

`ifndef SYNTHESIS
    a_rise_needs_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(adv && r_in_last))
        else $error("result appeared without a final byte");

    a_final_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_in_last && r_out_vld && !i_m_tready |=> r_in_vld && r_in_last)
        else $error("final byte lost while result slot busy");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_out.status != ST_FOUND) |->
            (r_out.value_start == '0) && (r_out.value_length == '0))
        else $error("offset or length set without found status");

    a_step_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !r_in_last |-> o_s_tready)
        else $error("non-final byte stalled");
`endif

endmodule

`default_nettype wire
